// ===== hw/rtl/horizon_mask_visibility_assert.svh =====
// Assertion macros for the horizon mask visibility block.
// Included inside the top-level module body; no other dependencies.
`ifndef HORIZON_MASK_VISIBILITY_ASSERT_SVH
`define HORIZON_MASK_VISIBILITY_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HMV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("horizon mask same-cycle check failed");

// Next-cycle implication, checked outside reset
`define HMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("horizon mask next-cycle check failed");

`endif

// ===== hw/rtl/hmv_pkg.sv =====
// Shared types and constants for the horizon mask visibility block.
// Used by the divider and the top level.
package hmv_pkg;

  // Default table depth
  localparam int DEF_MAX_POINTS = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Table entry: azimuth over elevation
  localparam int ANG_W   = 16;
  localparam int ENTRY_W = 2 * ANG_W;

  // Interpolation datapath widths
  localparam int SPAN_W     = 18;
  localparam int DE_W       = 17;
  localparam int PROD_W     = 35;
  localparam int DIV_NUM_W  = 34;
  localparam int DIV_DEN_W  = 17;
  localparam int DIV_REM_W  = 18;
  localparam int DIV_CYCLES = DIV_NUM_W / 2;
  localparam int DIV_CNT_W  = 5;
  localparam int LIM_W      = 36;

  // Implicit endpoint azimuth: one full turn
  localparam logic [ANG_W:0] FULL_TURN = 17'h10000;

  // Saturation limits of the reported elevation
  localparam logic signed [LIM_W-1:0] LIM_MAX = 36'sd32767;
  localparam logic signed [LIM_W-1:0] LIM_MIN = -36'sd32768;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_LINE = 2'd1,
    MODE_STEP = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_MODE   = 1'b0,
    REG_POINT_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DIVGO,
    ST_DIVW
  } state_e;

  typedef struct packed {
    logic                    cmd;
    logic [4:0]              point_index;
    logic [ANG_W-1:0]        azimuth;
    logic signed [ANG_W-1:0] elevation;
  } hmv_in_t;

  typedef struct packed {
    logic                    visible;
    logic signed [ANG_W-1:0] mask_elevation;
  } hmv_res_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic                 done;
    logic                 rem_nz;
    logic [DIV_NUM_W-1:0] quot;
  } div_res_t;

endpackage

// ===== hw/rtl/hmv_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No package dependencies.
module hmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hmv_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on hmv_pkg for widths and the status struct.
module hmv_div import hmv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] dividend_i,
  input  logic [DIV_DEN_W-1:0] divisor_i,
  output div_res_t             res_o
);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_REM_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;

  // Two restoring steps per cycle; the quotient shifts into the dividend register
  always_comb begin
    logic [DIV_REM_W-1:0] r;
    logic [DIV_NUM_W-1:0] n;
    r      = rem_q;
    n      = num_q;
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = DIV_CNT_W'(DIV_CYCLES);
      den_d = divisor_i;
      n     = dividend_i;
      r     = '0;
    end else if (run_q) begin
      for (int k = 0; k < 2; k++) begin
        r = {r[DIV_REM_W-2:0], n[DIV_NUM_W-1]};
        n = {n[DIV_NUM_W-2:0], 1'b0};
        if (r >= {1'b0, den_q}) begin
          r    = r - {1'b0, den_q};
          n[0] = 1'b1;
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
    num_d = n;
    rem_d = r;
  end

  // Hold control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign res_o.done   = done_q;
  assign res_o.rem_nz = (rem_q != '0);
  assign res_o.quot   = num_q;

endmodule

// ===== hw/rtl/horizon_mask_visibility.sv =====
// Horizon mask visibility: mask table in one RAM, walked serially per query.
// Load: one RAM write, in idle. No-mask query: result registered from idle. Step query:
// walks k entries (at most point_count + 1, one RAM read each), then compares.
// Line query: the same walk, then a multiply and the divider.
// Reset clears mode to no mask and point count to 1; the table is not cleared.
// Results are strobed on done_o for one cycle; busy_o is low then; no stall.
module horizon_mask_visibility import hmv_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  hmv_in_t               in_i,
  output logic                  done_o,
  output hmv_res_t              res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_e                  state_q, state_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [1:0]              mode_q;
  logic [CFG_DATA_W-1:0]   pc_q;
  logic                    done_q, done_d;
  hmv_res_t                res_q, res_d;

  logic [ANG_W-1:0]        az_q, az_d;
  logic signed [ANG_W-1:0] el_q, el_d;
  logic [ANG_W-1:0]        a0_q, a0_d;
  logic signed [ANG_W-1:0] e0_q, e0_d;
  logic [ANG_W:0]          a1_q, a1_d;
  logic signed [ANG_W-1:0] e1_q, e1_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [SPAN_W-1:0] span_q, span_d;
  logic                    neg_q, neg_d;

  logic [CW-1:0]           n_c;
  logic                    accept;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [AW-1:0]           ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [ANG_W-1:0]        rd_a;
  logic signed [ANG_W-1:0] rd_e;

  logic signed [SPAN_W-1:0] span_c;
  logic signed [SPAN_W-1:0] delta_c;
  logic signed [DE_W-1:0]   de_c;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [SPAN_W-1:0] span_abs;
  logic signed [LIM_W-1:0]  qs_c;
  logic signed [LIM_W-1:0]  lim_c;
  logic                     div_start;
  div_res_t                 div_res;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // Clamp the point count to 1..MAX_POINTS
  always_comb begin
    if (pc_q == '0) begin
      n_c = CW'(1);
    end else if (32'(pc_q) > 32'(MAX_POINTS)) begin
      n_c = CW'(MAX_POINTS);
    end else begin
      n_c = CW'(pc_q);
    end
  end

  // Table RAM: loads write in idle, queries read entry 0 then idx + 1
  assign ram_we    = accept && (in_i.cmd == CMD_LOAD) &&
                     (32'(in_i.point_index) < 32'(MAX_POINTS));
  assign ram_waddr = AW'(in_i.point_index);
  assign ram_raddr = (state_q == ST_SCAN) ? AW'(idx_q + 1'b1) : '0;

  hmv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_i.azimuth, in_i.elevation}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_a = ram_rdata[ENTRY_W-1:ANG_W];
  assign rd_e = $signed(ram_rdata[ANG_W-1:0]);

  // Interpolation operands
  assign span_c   = $signed({1'b0, a1_q}) - $signed({2'b00, a0_q});
  assign delta_c  = $signed({2'b00, az_q}) - $signed({2'b00, a0_q});
  assign de_c     = DE_W'(e1_q) - DE_W'(e0_q);
  assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
  assign span_abs = span_q[SPAN_W-1] ? -span_q : span_q;
  assign div_start = (state_q == ST_DIVGO);

  hmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_abs[DIV_NUM_W-1:0]),
    .divisor_i  (span_abs[DIV_DEN_W-1:0]),
    .res_o      (div_res)
  );

  // Signed quotient rounded up: truncation for negative, bump for positive remainders
  always_comb begin
    if (neg_q) begin
      qs_c = -$signed({{(LIM_W-DIV_NUM_W){1'b0}}, div_res.quot});
    end else begin
      qs_c = $signed({{(LIM_W-DIV_NUM_W){1'b0}}, div_res.quot}) +
             $signed({{(LIM_W-1){1'b0}}, div_res.rem_nz});
    end
    if (state_q == ST_EVAL) begin
      lim_c = LIM_W'(e0_q);
    end else begin
      lim_c = LIM_W'(e0_q) + qs_c;
    end
  end

  // Sequencer: next state, datapath updates and result
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    res_d   = res_q;
    az_d    = az_q;
    el_d    = el_q;
    a0_d    = a0_q;
    e0_d    = e0_q;
    a1_d    = a1_q;
    e1_d    = e1_q;
    prod_d  = prod_q;
    span_d  = span_q;
    neg_d   = neg_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.cmd == CMD_QUERY)) begin
          az_d = in_i.azimuth;
          el_d = in_i.elevation;
          if ((mode_q == MODE_LINE) || (mode_q == MODE_STEP)) begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end else begin
            done_d               = 1'b1;
            res_d.visible        = 1'b1;
            res_d.mask_elevation = '0;
          end
        end
      end
      ST_SCAN: begin
        // Advance past entry 0 always, then while the boundary is below the azimuth
        if ((idx_q == '0) || ((idx_q < n_c) && (az_q > rd_a))) begin
          a0_d  = rd_a;
          e0_d  = rd_e;
          idx_d = idx_q + 1'b1;
        end else begin
          if (idx_q < n_c) begin
            a1_d = {1'b0, rd_a};
            e1_d = rd_e;
          end else begin
            a1_d = FULL_TURN;
            e1_d = e0_q;
          end
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if ((mode_q == MODE_STEP) || (span_c == '0)) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          prod_d  = de_c * delta_c;
          span_d  = span_c;
          state_d = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        neg_d   = prod_q[PROD_W-1] ^ span_q[SPAN_W-1];
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_res.done) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // Compare against the unsaturated limit, report it saturated
    if ((state_q == ST_EVAL) || (state_q == ST_DIVW)) begin
      res_d.visible = (LIM_W'(el_q) >= lim_c);
      if (lim_c > LIM_MAX) begin
        res_d.mask_elevation = LIM_MAX[ANG_W-1:0];
      end else if (lim_c < LIM_MIN) begin
        res_d.mask_elevation = LIM_MIN[ANG_W-1:0];
      end else begin
        res_d.mask_elevation = lim_c[ANG_W-1:0];
      end
    end
  end

  // Control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
      mode_q  <= MODE_NONE;
      pc_q    <= CFG_DATA_W'(1);
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MASK_MODE:   mode_q <= cfg_data_i[1:0];
          REG_POINT_COUNT: pc_q   <= cfg_data_i;
          default:         pc_q   <= pc_q;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    az_q   <= az_d;
    el_q   <= el_d;
    a0_q   <= a0_d;
    e0_q   <= e0_d;
    a1_q   <= a1_d;
    e1_q   <= e1_d;
    prod_q <= prod_d;
    span_q <= span_d;
    neg_q  <= neg_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  `include "horizon_mask_visibility_assert.svh"

  `HMV_ASSERT_IMPL(a_scan_bound, clk_i, rst_ni, state_q == ST_SCAN, idx_q <= n_c)
  `HMV_ASSERT_IMPL(a_div_done_waiting, clk_i, rst_ni, div_res.done, state_q == ST_DIVW)
  `HMV_ASSERT_NEXT(a_load_no_result, clk_i, rst_ni, accept && (in_i.cmd == CMD_LOAD), !done_o)

endmodule
